// File: rtl/serial_reply_frame_checker_assert.svh
// Assertion macros shared by the frame checker RTL.
// Clocked on clk and disabled while rst_n is low; no other dependencies.
`ifndef SERIAL_REPLY_FRAME_CHECKER_ASSERT_SVH
`define SERIAL_REPLY_FRAME_CHECKER_ASSERT_SVH

// Check that a property holds on every clock edge out of reset.
`define SRFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SRFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/srfc_pkg.sv
// Types, constants and helper functions for the serial reply frame checker.
// Used by every module of the block; depends on nothing.
package srfc_pkg;

  localparam int MAX_FRAME = 560;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int HDR_LEN   = 10;
  localparam int CRC_FIRST = 6;

  localparam logic [7:0]  SYNC_A        = 8'hEB;
  localparam logic [7:0]  SYNC_B        = 8'h90;
  localparam logic [7:0]  CMD_BYTE      = 8'hA0;
  localparam logic [7:0]  LEN_BYTE      = 8'h2E;
  localparam logic [15:0] DEVICE_ID_RST = 16'h0016;
  localparam logic [9:0]  MIN_BYTES_RST = 10'd51;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // Operation carried in the input tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_GAP  = 1'b1;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_CRC      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  REG_DEVICE_ID = 2'd0;
  localparam logic [1:0]  REG_MIN_BYTES = 2'd1;

  localparam int OUT_DATA_W = 144;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] device_id;
    logic [9:0]  min_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [15:0] battery_voltage_raw;
    logic [17:0] charge_current_sum;
    logic [15:0] pv_voltage_raw;
    logic [15:0] internal_temp_raw;
    logic [15:0] battery_temp_raw;
    logic [7:0]  charger_mode;
    logic [15:0] pv_power_raw;
    logic [31:0] energy_raw;
  } result_t;

  // One byte of CRC-16, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Expected header byte at positions 0 to 9
  function automatic logic [7:0] hdr_byte(logic [3:0] i, logic [15:0] id);
    logic [7:0] v;
    case (i) inside
      4'd0, 4'd2, 4'd4: v = SYNC_A;
      4'd1, 4'd3, 4'd5: v = SYNC_B;
      4'd6:             v = id[7:0];
      4'd7:             v = id[15:8];
      4'd8:             v = CMD_BYTE;
      default:          v = LEN_BYTE;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/srfc_in_reg.sv
// Input register stage of the frame checker: holds one word from the input stream.
// Depends on srfc_pkg.
module srfc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // rx_byte[7:0]
  input  logic [0:0]         in_tuser,   // operation[0]
  input  logic               fire,
  output logic               item_valid,
  output srfc_pkg::item_t    item
);

  logic            valid_r;
  srfc_pkg::item_t item_r;

  // take a new word when empty or whenever the held one moves on
  assign in_tready  = !valid_r || fire;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op   <= in_tuser[0];
      item_r.data <= in_tdata;
    end
  end

endmodule

// File: rtl/srfc_frame.sv
// Per-frame state of the frame checker: byte count, header check, CRC, payload capture.
// Depends on srfc_pkg and serial_reply_frame_checker_assert.svh.
`include "serial_reply_frame_checker_assert.svh"

module srfc_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  srfc_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  srfc_pkg::item_t   item,
  input  logic              out_free,
  output logic              fire,
  output logic              res_load,
  output srfc_pkg::result_t res
);

  logic [srfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail_r [3];
  logic [7:0]  tail_nxt [3];
  logic        hdr_ok_r, hdr_ok_nxt;
  logic        ovf_r, ovf_nxt;

  // captured payload words
  logic [15:0] bv_r, bv_nxt;
  logic [15:0] cc0_r, cc0_nxt;
  logic [15:0] cc1_r, cc1_nxt;
  logic [15:0] cc2_r, cc2_nxt;
  logic [15:0] pvv_r, pvv_nxt;
  logic [15:0] itmp_r, itmp_nxt;
  logic [15:0] btmp_r, btmp_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [15:0] pvp_r, pvp_nxt;
  logic [31:0] egy_r, egy_nxt;

  logic        is_gap;
  logic [7:0]  b;
  logic [15:0] rx_crc;
  logic        cnt_at_max;

  assign is_gap   = (item.op == srfc_pkg::OP_GAP);
  assign b        = item.data;
  // a gap needs a free output slot, a byte never waits
  assign fire     = item_valid && (!is_gap || out_free);
  assign res_load = fire && is_gap;
  assign rx_crc   = {tail_r[2], tail_r[1]};
  assign cnt_at_max = (cnt_r == srfc_pkg::CNT_W'(srfc_pkg::MAX_FRAME));

  always_comb begin
    res.battery_voltage_raw = bv_r;
    res.charge_current_sum  = {2'b00, cc0_r} + {2'b00, cc1_r} + {2'b00, cc2_r};
    res.pv_voltage_raw      = pvv_r;
    res.internal_temp_raw   = itmp_r;
    res.battery_temp_raw    = btmp_r;
    res.charger_mode        = mode_r;
    res.pv_power_raw        = pvp_r;
    res.energy_raw          = egy_r;
    if (ovf_r) begin
      res.frame_status = srfc_pkg::ST_OVERFLOW;
    end else if (cnt_r < srfc_pkg::CNT_W'(cfg.min_frame_bytes) ||
                 cnt_r < srfc_pkg::CNT_W'(9)) begin
      res.frame_status = srfc_pkg::ST_SHORT;
    end else if (cnt_r < srfc_pkg::CNT_W'(srfc_pkg::HDR_LEN) || !hdr_ok_r) begin
      res.frame_status = srfc_pkg::ST_HEADER;
    end else if (rx_crc != crc_r) begin
      res.frame_status = srfc_pkg::ST_CRC;
    end else begin
      res.frame_status = srfc_pkg::ST_OK;
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    tail_nxt   = tail_r;
    hdr_ok_nxt = hdr_ok_r;
    ovf_nxt    = ovf_r;
    bv_nxt     = bv_r;
    cc0_nxt    = cc0_r;
    cc1_nxt    = cc1_r;
    cc2_nxt    = cc2_r;
    pvv_nxt    = pvv_r;
    itmp_nxt   = itmp_r;
    btmp_nxt   = btmp_r;
    mode_nxt   = mode_r;
    pvp_nxt    = pvp_r;
    egy_nxt    = egy_r;
    if (fire && is_gap) begin
      // result taken: clear the frame
      cnt_nxt    = '0;
      crc_nxt    = '0;
      tail_nxt   = '{default: 8'h00};
      hdr_ok_nxt = 1'b1;
      ovf_nxt    = 1'b0;
      bv_nxt     = '0;
      cc0_nxt    = '0;
      cc1_nxt    = '0;
      cc2_nxt    = '0;
      pvv_nxt    = '0;
      itmp_nxt   = '0;
      btmp_nxt   = '0;
      mode_nxt   = '0;
      pvp_nxt    = '0;
      egy_nxt    = '0;
    end else if (fire) begin
      if (cnt_r >= srfc_pkg::CNT_W'(srfc_pkg::MAX_FRAME)) begin
        // drop the byte, hold the count
        ovf_nxt = 1'b1;
      end else begin
        if (cnt_r < srfc_pkg::CNT_W'(srfc_pkg::HDR_LEN) &&
            b != srfc_pkg::hdr_byte(cnt_r[3:0], cfg.device_id)) begin
          hdr_ok_nxt = 1'b0;
        end
        // the byte leaving the delay line enters the CRC
        if (cnt_r >= srfc_pkg::CNT_W'(srfc_pkg::CRC_FIRST + 3)) begin
          crc_nxt = srfc_pkg::crc_update(crc_r, tail_r[2]);
        end
        tail_nxt[2] = tail_r[1];
        tail_nxt[1] = tail_r[0];
        tail_nxt[0] = b;
        cnt_nxt     = cnt_r + 1'b1;
        case (cnt_r)
          10'd10:  bv_nxt[7:0]     = b;
          10'd11:  bv_nxt[15:8]    = b;
          10'd12:  cc0_nxt[7:0]    = b;
          10'd13:  cc0_nxt[15:8]   = b;
          10'd14:  cc1_nxt[7:0]    = b;
          10'd15:  cc1_nxt[15:8]   = b;
          10'd16:  cc2_nxt[7:0]    = b;
          10'd17:  cc2_nxt[15:8]   = b;
          10'd18:  pvv_nxt[7:0]    = b;
          10'd19:  pvv_nxt[15:8]   = b;
          10'd24:  itmp_nxt[7:0]   = b;
          10'd25:  itmp_nxt[15:8]  = b;
          10'd26:  btmp_nxt[7:0]   = b;
          10'd27:  btmp_nxt[15:8]  = b;
          10'd30:  mode_nxt        = b;
          10'd50:  pvp_nxt[7:0]    = b;
          10'd51:  pvp_nxt[15:8]   = b;
          10'd52:  egy_nxt[7:0]    = b;
          10'd53:  egy_nxt[15:8]   = b;
          10'd54:  egy_nxt[23:16]  = b;
          10'd55:  egy_nxt[31:24]  = b;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      crc_r    <= '0;
      tail_r   <= '{default: 8'h00};
      hdr_ok_r <= 1'b1;
      ovf_r    <= 1'b0;
      bv_r     <= '0;
      cc0_r    <= '0;
      cc1_r    <= '0;
      cc2_r    <= '0;
      pvv_r    <= '0;
      itmp_r   <= '0;
      btmp_r   <= '0;
      mode_r   <= '0;
      pvp_r    <= '0;
      egy_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      tail_r   <= tail_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      ovf_r    <= ovf_nxt;
      bv_r     <= bv_nxt;
      cc0_r    <= cc0_nxt;
      cc1_r    <= cc1_nxt;
      cc2_r    <= cc2_nxt;
      pvv_r    <= pvv_nxt;
      itmp_r   <= itmp_nxt;
      btmp_r   <= btmp_nxt;
      mode_r   <= mode_nxt;
      pvp_r    <= pvp_nxt;
      egy_r    <= egy_nxt;
    end
  end

  `SRFC_ASSERT(a_cnt_bound, cnt_r <= srfc_pkg::CNT_W'(srfc_pkg::MAX_FRAME), "count past limit")
  `SRFC_ASSERT_IMP(a_ovf_full, ovf_r, cnt_at_max, "overflow below limit")
  `SRFC_ASSERT_NEXT(a_gap_clear, res_load, cnt_r == '0 && !ovf_r && hdr_ok_r, "frame not cleared")

endmodule

// File: rtl/srfc_out_reg.sv
// Output register of the frame checker: holds one result word until the sink takes it.
// Depends on srfc_pkg and serial_reply_frame_checker_assert.svh.
`include "serial_reply_frame_checker_assert.svh"

module srfc_out_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  srfc_pkg::result_t                  res,
  output logic                               out_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // battery_voltage_raw[15:0], charge_current_sum[33:16], pv_voltage_raw[49:34],
  // internal_temp_raw[65:50], battery_temp_raw[81:66], charger_mode[89:82],
  // pv_power_raw[105:90], energy_raw[137:106], zero fill [143:138]
  output logic [srfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [2:0]                         out_tuser  // frame_status[2:0]
);

  logic              valid_r;
  srfc_pkg::result_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.frame_status;
  assign out_tdata  = {6'b0, res_r.energy_raw, res_r.pv_power_raw, res_r.charger_mode,
                       res_r.battery_temp_raw, res_r.internal_temp_raw, res_r.pv_voltage_raw,
                       res_r.charge_current_sum, res_r.battery_voltage_raw};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  `SRFC_ASSERT_IMP(a_load_free, load, out_free, "result loaded over a waiting word")

endmodule

// File: rtl/serial_reply_frame_checker.sv
// Timing: an accepted word is held in the input register and processed from there; a gap's
// result is loaded into the output register, which drives out_tvalid.
// Throughput: one word per cycle; the input register and the output register part the
// two sides, and only a gap waits on a full output register.
// Reset: rst_n synchronous, active low; clears the frame, both stream registers and
// loads device_id 22 and min_frame_bytes 51.

// Top level of the serial reply frame checker.
// Depends on srfc_pkg, srfc_in_reg, srfc_frame and srfc_out_reg.
module serial_reply_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [srfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // rx_byte[7:0]
  input  logic [0:0]                          in_tuser,   // operation[0]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // battery_voltage_raw[15:0], charge_current_sum[33:16], pv_voltage_raw[49:34],
  // internal_temp_raw[65:50], battery_temp_raw[81:66], charger_mode[89:82],
  // pv_power_raw[105:90], energy_raw[137:106], zero fill [143:138]
  output logic [srfc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [2:0]                          out_tuser   // frame_status[2:0]
);

  srfc_pkg::cfg_t    cfg_r;
  srfc_pkg::item_t   item;
  srfc_pkg::result_t res;
  logic              item_valid;
  logic              fire;
  logic              res_load;
  logic              out_free;

  // Configuration registers: to be written by the user only while the block is idle, so no
  // shadowing is needed; the block itself does not enforce this. An index beyond the two registers is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_id       <= srfc_pkg::DEVICE_ID_RST;
      cfg_r.min_frame_bytes <= srfc_pkg::MIN_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srfc_pkg::REG_DEVICE_ID: cfg_r.device_id       <= cfg_wdata;
        srfc_pkg::REG_MIN_BYTES: cfg_r.min_frame_bytes <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Input register: holds the word until the frame logic consumes it.
  srfc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // Frame logic: a received byte updates count, header flag, CRC and payload, or past the
  // frame limit is dropped and flags overflow; a gap evaluates the frame, loads the result and clears.
  srfc_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .fire       (fire),
    .res_load   (res_load),
    .res        (res)
  );

  // Output register: a result waits here while new bytes keep flowing in.
  srfc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
